// ----- src/spi_master_mode_engine_defines.svh -----
// Assertion macros shared by the SPI master mode engine RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SPI_MASTER_MODE_ENGINE_DEFINES_SVH
`define SPI_MASTER_MODE_ENGINE_DEFINES_SVH

// Check that is switched off while reset is held
`define SMME_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that also holds through reset
`define SMME_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- src/smme_pkg.sv -----
// Shared types and constants for the SPI master mode engine.
// No dependencies; imported by the core and the top level.
`default_nettype none

package smme_pkg;

    // Word length default and fixed field widths
    localparam int DEFAULT_WORD_BITS = 8;
    localparam int HALF_W            = 16;
    localparam int BYTE_W            = 8;
    localparam int CFG_IDX_W         = 2;

    // Reset value of the half period register
    localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLARITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LSB      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF     = 2'd3;

    // Command codes carried with each item
    typedef enum logic [1:0] {
        FN_IDLE    = 2'd0,
        FN_START   = 2'd1,
        FN_SELECT  = 2'd2,
        FN_RELEASE = 2'd3
    } t_func;

    // Transfer phase
    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_LOW_HALF  = 2'd1,
        PH_HIGH_HALF = 2'd2
    } t_phase;

    // Configuration seen by the core
    typedef struct packed {
        logic              polarity;
        logic              phase;
        logic              lsb_first;
        logic [HALF_W-1:0] half_period;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic              sck;
        logic              mosi;
        logic              cs_n;
        logic              busy_res;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
    } t_result;

endpackage

`default_nettype wire

// ----- src/smme_core.sv -----
// Per-tick SPI line state machine: line levels, shift registers and counters.
// Depends on smme_pkg; instantiated by spi_master_mode_engine.
`default_nettype none

module smme_core #(
    parameter int WORD_BITS = smme_pkg::DEFAULT_WORD_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire smme_pkg::t_cfg              i_cfg,
    input  wire logic [1:0]                  i_func,
    input  wire logic [smme_pkg::BYTE_W-1:0] i_tx_byte,
    input  wire logic                        i_miso,
    output smme_pkg::t_result                o_res
);
    import smme_pkg::*;

    localparam int CNT_W = $clog2(WORD_BITS + 1);
    localparam int IDX_W = $clog2(WORD_BITS);
    localparam int EXT_W = (WORD_BITS > BYTE_W) ? WORD_BITS : BYTE_W;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WORD_BITS);
    localparam logic [IDX_W-1:0] TOP_IDX  = IDX_W'(WORD_BITS - 1);

    t_phase                 r_phase, n_phase;
    logic                   r_sck, n_sck;
    logic                   r_mosi, n_mosi;
    logic                   r_cs_n, n_cs_n;
    logic [CNT_W-1:0]       r_bit, n_bit;
    logic [HALF_W-1:0]      r_wait, n_wait;
    logic [WORD_BITS-1:0]   r_send, n_send;
    logic [WORD_BITS-1:0]   r_recv, n_recv;

    logic                   valid;
    logic                   samp_ok;
    logic [HALF_W-1:0]      half_m1;
    logic [CNT_W-1:0]       bit_inc;
    logic [IDX_W-1:0]       pos_cur;
    logic [IDX_W-1:0]       pos_inc;
    logic [IDX_W-1:0]       pos_first;
    logic [WORD_BITS-1:0]   tx_word;
    logic [EXT_W-1:0]       recv_ext;

    // Bit positions for the current and the following bit
    assign half_m1   = (i_cfg.half_period == '0) ? '0 : i_cfg.half_period - 1'b1;
    assign bit_inc   = r_bit + 1'b1;
    assign pos_cur   = i_cfg.lsb_first ? r_bit[IDX_W-1:0] : TOP_IDX - r_bit[IDX_W-1:0];
    assign pos_inc   = i_cfg.lsb_first ? bit_inc[IDX_W-1:0] : TOP_IDX - bit_inc[IDX_W-1:0];
    assign pos_first = i_cfg.lsb_first ? '0 : TOP_IDX;
    assign tx_word   = WORD_BITS'(i_tx_byte);
    // a sample past the last bit (mode switched mid-byte) falls outside the word
    assign samp_ok   = (r_bit < LAST_CNT);

    // Next state for one tick
    always_comb begin
        n_phase = r_phase;
        n_sck   = r_sck;
        n_mosi  = r_mosi;
        n_cs_n  = r_cs_n;
        n_bit   = r_bit;
        n_wait  = r_wait;
        n_send  = r_send;
        n_recv  = r_recv;
        valid   = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                n_sck = i_cfg.polarity;
                unique case (t_func'(i_func))
                    FN_START: begin
                        n_send = tx_word;
                        n_recv = '0;
                        n_bit  = '0;
                        n_wait = half_m1;
                        n_mosi = tx_word[pos_first];
                        if (!i_cfg.phase) begin
                            n_phase = PH_LOW_HALF;
                        end else begin
                            n_sck   = ~i_cfg.polarity;
                            n_phase = PH_HIGH_HALF;
                        end
                    end
                    FN_SELECT:  n_cs_n = 1'b0;
                    FN_RELEASE: n_cs_n = 1'b1;
                    default: ;
                endcase
            end
            PH_LOW_HALF: begin
                if (r_wait != '0) begin
                    n_wait = r_wait - 1'b1;
                end else if (!i_cfg.phase) begin
                    // leading edge, sample
                    n_sck          = ~i_cfg.polarity;
                    if (samp_ok) begin
                        n_recv[pos_cur] = r_recv[pos_cur] | i_miso;
                    end
                    n_phase        = PH_HIGH_HALF;
                    n_wait         = half_m1;
                end else if (r_bit >= LAST_CNT) begin
                    n_phase = PH_IDLE;
                    valid   = 1'b1;
                end else begin
                    // leading edge, drive next bit
                    n_sck   = ~i_cfg.polarity;
                    n_mosi  = r_send[pos_cur];
                    n_phase = PH_HIGH_HALF;
                    n_wait  = half_m1;
                end
            end
            PH_HIGH_HALF: begin
                if (r_wait != '0) begin
                    n_wait = r_wait - 1'b1;
                end else begin
                    // trailing edge
                    n_sck = i_cfg.polarity;
                    if (i_cfg.phase && samp_ok) begin
                        n_recv[pos_cur] = r_recv[pos_cur] | i_miso;
                    end
                    n_bit = bit_inc;
                    if (!i_cfg.phase && bit_inc >= LAST_CNT) begin
                        n_phase = PH_IDLE;
                        valid   = 1'b1;
                    end else begin
                        if (!i_cfg.phase) begin
                            n_mosi = r_send[pos_inc];
                        end
                        n_phase = PH_LOW_HALF;
                        n_wait  = half_m1;
                    end
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // Result of this tick
    assign recv_ext = EXT_W'(n_recv);
    always_comb begin
        o_res.sck      = n_sck;
        o_res.mosi     = n_mosi;
        o_res.cs_n     = n_cs_n;
        o_res.busy_res = (n_phase != PH_IDLE);
        o_res.rx_valid = valid;
        o_res.rx_byte  = valid ? recv_ext[BYTE_W-1:0] : '0;
    end

    // State registers advance once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_sck   <= 1'b0;
            r_mosi  <= 1'b0;
            r_cs_n  <= 1'b1;
            r_bit   <= '0;
            r_wait  <= '0;
            r_send  <= '0;
            r_recv  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_sck   <= n_sck;
            r_mosi  <= n_mosi;
            r_cs_n  <= n_cs_n;
            r_bit   <= n_bit;
            r_wait  <= n_wait;
            r_send  <= n_send;
            r_recv  <= n_recv;
        end
    end

endmodule

`default_nettype wire

// ----- src/spi_master_mode_engine.sv -----
// SPI master engine, modes 0 to 3: one input item per bus tick, one result item per input.
// A result appears on m_axis in the cycle after its item is accepted.
// One item per cycle unless m_axis stalls; the output register is the only buffer.
// Reset (synchronous, active low): chip select released, SCK low, config to defaults.
// Depends on smme_pkg, smme_core and spi_master_mode_engine_defines.svh.
`default_nettype none

`include "spi_master_mode_engine_defines.svh"

module spi_master_mode_engine #(
    parameter int WORD_BITS = smme_pkg::DEFAULT_WORD_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [smme_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [smme_pkg::HALF_W-1:0]     i_cfg_data,
    // item input
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [15:0]                     s_axis_tdata,  // [7:0] tx_byte, [8] miso
    input  wire logic [1:0]                      s_axis_tuser,  // [1:0] func
    // result output
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [15:0]                          m_axis_tdata   // [0] sck, [1] mosi,
                                                                // [2] cs_n, [3] busy_res,
                                                                // [4] rx_valid, [12:5] rx_byte
);
    import smme_pkg::*;

    t_cfg    r_cfg;
    t_result core_res;
    t_result r_out;
    logic    r_out_valid;
    logic    accept;

    // Configuration registers, ready whenever out of reset
    assign o_cfg_ready = i_rst_n;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.polarity    <= 1'b0;
            r_cfg.phase       <= 1'b0;
            r_cfg.lsb_first   <= 1'b0;
            r_cfg.half_period <= HALF_PERIOD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POLARITY: r_cfg.polarity    <= i_cfg_data[0];
                CFG_PHASE:    r_cfg.phase       <= i_cfg_data[0];
                CFG_LSB:      r_cfg.lsb_first   <= i_cfg_data[0];
                CFG_HALF:     r_cfg.half_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Take a new item whenever the output register is free or draining
    assign s_axis_tready = i_rst_n && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    smme_core #(
        .WORD_BITS(WORD_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (accept),
        .i_cfg     (r_cfg),
        .i_func    (s_axis_tuser),
        .i_tx_byte (s_axis_tdata[7:0]),
        .i_miso    (s_axis_tdata[8]),
        .o_res     (core_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.rx_byte, r_out.rx_valid, r_out.busy_res,
                            r_out.cs_n, r_out.mosi, r_out.sck};

    // Checks
    `SMME_ASSERT(a_done_not_busy, r_out_valid && r_out.rx_valid |-> !r_out.busy_res, "completed transfer still busy")
    `SMME_ASSERT(a_rx_zero_idle, r_out_valid && !r_out.rx_valid |-> r_out.rx_byte == '0, "rx_byte nonzero without rx_valid")
    `SMME_ASSERT(a_accept_fills, accept |=> m_axis_tvalid, "accepted item produced no result")
    `SMME_ASSERT_ALWAYS(a_no_accept_in_reset, !i_rst_n |-> !s_axis_tready, "item accepted during reset")

endmodule

`default_nettype wire
